### rtl/amgt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amgt_pkg
// Shared field widths, stream packing offsets, register map and mode codes
// for the adjacency-matrix graph traversal block.
// ---------------------------------------------------------------------------
package amgt_pkg;

   // item field widths
   localparam int MODE_W = 2;
   localparam int NODE_W = 5;
   localparam int ROW_W  = 32;
   localparam int CNT_W  = 6;

   // largest graph the fixed field widths can describe
   localparam int NODE_LIMIT = 32;

   // request tdata: row_index, row_bits, start_node (lowest first), byte padded
   localparam int REQ_TDATA_W   = 48;
   localparam int ROW_INDEX_LSB = 0;
   localparam int ROW_BITS_LSB  = ROW_INDEX_LSB + NODE_W;
   localparam int START_LSB     = ROW_BITS_LSB + ROW_W;

   // response tdata: node; tuser: error, all_reached
   localparam int RSP_TDATA_W     = 8;
   localparam int RSP_TUSER_W     = 2;
   localparam int TUSER_ERROR_BIT = 0;
   localparam int TUSER_ALL_BIT   = 1;

   // register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_NODE_COUNT_ADDR = 2'd0;
   localparam logic [CNT_W-1:0]      NODE_COUNT_RESET    = 6'd32;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD = 2'd0,
      MODE_BFS  = 2'd1,
      MODE_DFS  = 2'd2
   } mode_type;

endpackage

### rtl/amgt_adj_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amgt_adj_mem
// Adjacency row store: one write port, one registered read port. Per-row
// valid bits make rows never loaded since reset read as zero.
// ---------------------------------------------------------------------------
module amgt_adj_mem #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] rows_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= rows_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### rtl/amgt_list_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amgt_list_mem
// Work list RAM (BFS queue / DFS stack): one write, one registered read.
// Contents undefined until written.
// ---------------------------------------------------------------------------
module amgt_list_mem #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 5,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/adjacency_matrix_graph_traversal.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adjacency_matrix_graph_traversal
// Adjacency bit matrix loaded row by row; BFS and DFS traversals stream out
// the visited nodes in order, flagging the last one and full reachability.
// ---------------------------------------------------------------------------
//
//  channel | direction | fields
//  --------+-----------+-----------------------------------------------------
//  req_*   | in        | tuser: mode; tdata: row_index, row_bits, start_node
//  rsp_*   | out       | tdata: node; tlast: last; tuser: error, all_reached
//  csr_*   | in/out    | node_count at byte address 0
//
//  Flow: a load or an unused mode leaves the block idle and ready for
//  the next request. Each work list pop reads the list entry and then
//  its adjacency row through the two RAMs in turn; a DFS push reads the
//  adjacency row of the pushed node directly.
//  Reset: synchronous; adjacency rows read as zero until loaded.
//  Stalls: rsp_tready low freezes the traversal at its next transfer; the
//  final result may wait in the output register while new items are taken.
// ---------------------------------------------------------------------------
module adjacency_matrix_graph_traversal #(
   parameter int MAX_NODES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [amgt_pkg::REQ_TDATA_W-1:0]    req_tdata,  // row_index, row_bits, start_node
   input  logic [amgt_pkg::MODE_W-1:0]         req_tuser,  // mode
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [amgt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // node
   output logic                                rsp_tlast,
   output logic [amgt_pkg::RSP_TUSER_W-1:0]    rsp_tuser,  // error, all_reached
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [amgt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [amgt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [amgt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import amgt_pkg::*;

   localparam int NODE_CAP = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
   localparam int IDX_W    = $clog2(NODE_CAP);
   localparam int PTR_W    = $clog2(NODE_CAP + 1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_POP    = 7'b0000010,   // read work list head / stack top
      S_LIST   = 7'b0000100,   // read adjacency row of listed node
      S_ROW    = 7'b0001000,   // read adjacency row of node just pushed
      S_LOAD   = 7'b0010000,   // capture unvisited neighbours
      S_SCAN   = 7'b0100000,   // take lowest neighbour per transfer
      S_FINISH = 7'b1000000    // release held node as last result
   } state_type;

   // lowest set bit of a one-hot word to its index
   function automatic logic [IDX_W-1:0] onehot_index(input logic [NODE_CAP-1:0] onehot);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int j = 0; j < NODE_CAP; j++) begin
         if (onehot[j]) begin
            idx = idx | IDX_W'(j);
         end
      end
      return idx;
   endfunction

   state_type             state_ff, state_in;
   logic                  is_bfs_ff, is_bfs_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;       // BFS tail or DFS depth
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [NODE_CAP-1:0]   cand_ff, cand_in;
   logic [NODE_CAP-1:0]   visited_ff, visited_in;
   logic [NODE_CAP-1:0]   mask_ff, mask_in;
   logic [NODE_W-1:0]     hold_node_ff, hold_node_in;
   logic                  hold_err_ff, hold_err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]     rsp_node_ff, rsp_node_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic                  rsp_all_ff, rsp_all_in;
   logic [CNT_W-1:0]      node_count_ff, node_count_in;

   // request fields
   mode_type              req_mode;
   logic [NODE_W-1:0]     req_row_index;
   logic [ROW_W-1:0]      req_row_bits;
   logic [NODE_W-1:0]     req_start;
   logic                  req_fire;

   logic [CNT_W-1:0]      count_eff;
   logic [NODE_CAP-1:0]   count_mask;
   logic                  start_bad;
   logic                  out_free;
   logic [NODE_CAP-1:0]   low_bit;
   logic [IDX_W-1:0]      low_idx;
   logic [PTR_W-1:0]      stack_top;
   logic                  csr_write;

   // memory ports
   logic                  adj_wr_en;
   logic [IDX_W-1:0]      adj_wr_addr;
   logic [NODE_CAP-1:0]   adj_wr_data;
   logic                  adj_rd_en;
   logic [IDX_W-1:0]      adj_rd_addr;
   logic [NODE_CAP-1:0]   adj_rd_data;
   logic                  list_wr_en;
   logic [IDX_W-1:0]      list_wr_addr;
   logic [IDX_W-1:0]      list_wr_data;
   logic                  list_rd_en;
   logic [IDX_W-1:0]      list_rd_addr;
   logic [IDX_W-1:0]      list_rd_data;

   assign req_mode      = mode_type'(req_tuser);
   assign req_row_index = req_tdata[ROW_INDEX_LSB +: NODE_W];
   assign req_row_bits  = req_tdata[ROW_BITS_LSB +: ROW_W];
   assign req_start     = req_tdata[START_LSB +: NODE_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // node count saturates at the matrix size
   assign count_eff = (node_count_ff > CNT_W'(NODE_CAP)) ? CNT_W'(NODE_CAP) : node_count_ff;
   assign start_bad = (CNT_W'(req_start) >= count_eff);

   always_comb begin
      for (int j = 0; j < NODE_CAP; j++) begin
         count_mask[j] = (CNT_W'(j) < count_eff);
      end
   end

   // output register slot can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // lowest unvisited neighbour
   assign low_bit = cand_ff & (~cand_ff + NODE_CAP'(1));
   assign low_idx = onehot_index(low_bit);

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_NODE_COUNT_ADDR)
                       ? CSR_DATA_W'(node_count_ff) : '0;
   assign node_count_in = (csr_write && csr_paddr == CSR_NODE_COUNT_ADDR)
                          ? csr_pwdata[CNT_W-1:0] : node_count_ff;

   // row loads
   assign adj_wr_en   = req_fire && (req_mode == MODE_LOAD)
                        && (CNT_W'(req_row_index) < CNT_W'(NODE_CAP));
   assign adj_wr_addr = req_row_index[IDX_W-1:0];
   assign adj_wr_data = req_row_bits[NODE_CAP-1:0];

   // row reads: listed node or node just pushed
   assign adj_rd_en   = (state_ff == S_LIST) || (state_ff == S_ROW);
   assign adj_rd_addr = (state_ff == S_LIST) ? list_rd_data : cur_ff;

   // work list reads: queue head or stack top
   assign stack_top    = ptr_ff - PTR_W'(1);
   assign list_rd_en   = (state_ff == S_POP);
   assign list_rd_addr = is_bfs_ff ? head_ff[IDX_W-1:0] : stack_top[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      is_bfs_in    = is_bfs_ff;
      head_in      = head_ff;
      ptr_in       = ptr_ff;
      cur_in       = cur_ff;
      cand_in      = cand_ff;
      visited_in   = visited_ff;
      mask_in      = mask_ff;
      hold_node_in = hold_node_ff;
      hold_err_in  = hold_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_node_in  = rsp_node_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_all_in   = rsp_all_ff;
      list_wr_en   = 1'b0;
      list_wr_addr = ptr_ff[IDX_W-1:0];
      list_wr_data = low_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_mode == MODE_BFS || req_mode == MODE_DFS)) begin
               is_bfs_in    = (req_mode == MODE_BFS);
               hold_node_in = req_start;
               if (start_bad) begin
                  // bad start: single error result, state untouched
                  hold_err_in = 1'b1;
                  state_in    = S_FINISH;
               end else begin
                  hold_err_in  = 1'b0;
                  mask_in      = count_mask;
                  visited_in   = NODE_CAP'(1) << req_start[IDX_W-1:0];
                  list_wr_en   = 1'b1;
                  list_wr_addr = '0;
                  list_wr_data = req_start[IDX_W-1:0];
                  head_in      = '0;
                  ptr_in       = PTR_W'(1);
                  state_in     = S_POP;
               end
            end
         end
         S_POP: begin
            if (is_bfs_ff) begin
               if (head_ff == ptr_ff) begin
                  state_in = S_FINISH;
               end else begin
                  head_in  = head_ff + PTR_W'(1);
                  state_in = S_LIST;
               end
            end else begin
               state_in = (ptr_ff == '0) ? S_FINISH : S_LIST;
            end
         end
         S_LIST: begin
            state_in = S_LOAD;
         end
         S_ROW: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cand_in  = adj_rd_data & mask_ff & ~visited_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cand_ff == '0) begin
               // row exhausted; DFS backtracks one level
               if (!is_bfs_ff) begin
                  ptr_in = ptr_ff - PTR_W'(1);
               end
               state_in = S_POP;
            end else if (out_free) begin
               // previous node goes out, new one is held until its successor is known
               rsp_valid_in = 1'b1;
               rsp_node_in  = hold_node_ff;
               rsp_last_in  = 1'b0;
               rsp_err_in   = 1'b0;
               rsp_all_in   = 1'b0;
               hold_node_in = NODE_W'(low_idx);
               visited_in   = visited_ff | low_bit;
               cand_in      = cand_ff & ~low_bit;
               list_wr_en   = 1'b1;
               ptr_in       = ptr_ff + PTR_W'(1);
               if (!is_bfs_ff) begin
                  cur_in   = low_idx;
                  state_in = S_ROW;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = hold_node_ff;
               rsp_last_in  = 1'b1;
               rsp_err_in   = hold_err_ff;
               rsp_all_in   = !hold_err_ff && (visited_ff == mask_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= NODE_COUNT_RESET;
         head_ff       <= '0;
         ptr_ff        <= '0;
         is_bfs_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
         head_ff       <= head_in;
         ptr_ff        <= ptr_in;
         is_bfs_ff     <= is_bfs_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cand_ff      <= cand_in;
      visited_ff   <= visited_in;
      mask_ff      <= mask_in;
      hold_node_ff <= hold_node_in;
      hold_err_ff  <= hold_err_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_all_ff   <= rsp_all_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_node_ff);
   assign rsp_tlast  = rsp_last_ff;
   always_comb begin
      rsp_tuser                  = '0;
      rsp_tuser[TUSER_ERROR_BIT] = rsp_err_ff;
      rsp_tuser[TUSER_ALL_BIT]   = rsp_all_ff;
   end

   amgt_adj_mem #(
      .DEPTH  (NODE_CAP),
      .WIDTH  (NODE_CAP),
      .ADDR_W (IDX_W)
   ) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   amgt_list_mem #(
      .DEPTH  (NODE_CAP),
      .WIDTH  (IDX_W),
      .ADDR_W (IDX_W)
   ) u_list_mem (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

endmodule

### rtl/amgt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amgt_checker
// Port-level checks on the traversal block, bound to the top level.
// ---------------------------------------------------------------------------
module amgt_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [amgt_pkg::MODE_W-1:0]       req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [amgt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic [amgt_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   import amgt_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // error result stands alone
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[TUSER_ERROR_BIT] |-> rsp_tlast
         && !rsp_tuser[TUSER_ALL_BIT])
      else $error("error result not a lone last transfer");

   // reachability flag only on the closing transfer
   a_all_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[TUSER_ALL_BIT] |-> rsp_tlast)
      else $error("all_reached outside last transfer");

   // a traversal closes the request side
   a_trav_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_BFS || req_tuser == MODE_DFS)
         |=> !req_tready)
      else $error("request taken during traversal");

   // a row load leaves the request side open
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_LOAD) |=> req_tready)
      else $error("row load stalled the request side");

endmodule

bind adjacency_matrix_graph_traversal amgt_checker u_amgt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adjacency-matrix graph traversal block. Rows
// are loaded over the request stream. Each BFS or DFS transfer is run
// through a local copy of the graph, which yields the ordered list of
// visits it should produce. Response transfers are compared field by field
// against that list. A short directed table runs first, then random phases,
// each with its own node_count. Both streams idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
   import amgt_pkg::*;

   // mode code with no meaning; the block must drop it silently
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int GAP_MAX         = 19;
   // quiet wait after the last owed visit, before the next register write
   localparam int DRAIN_CYCLES    = 256;
   localparam int QUIET_LIMIT     = 4000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 16;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              last;
      logic              error;
      logic              all_reached;
   } visit_type;

   // one row of the directed table; also reused for random transfers
   typedef struct packed {
      logic              is_csr;
      logic [CNT_W-1:0]  node_count;
      logic [MODE_W-1:0] mode;
      logic [NODE_W-1:0] row_index;
      logic [ROW_W-1:0]  row_bits;
      logic [NODE_W-1:0] start_node;
      logic              typed;
      visit_type         typed_visit;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;   // row_index, row_bits, start_node
   logic [MODE_W-1:0]        req_tuser;   // mode
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;   // node
   logic                     rsp_tlast;
   logic [RSP_TUSER_W-1:0]   rsp_tuser;   // error, all_reached
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // local copy of the graph and the register
   logic [ROW_W-1:0] adj_rows [NODE_LIMIT];
   logic [ROW_W-1:0] visited_nodes;
   logic [CNT_W-1:0] nodes_in_use;

   visit_type    walk_out[$];        // visits of the transfer just accepted
   visit_type    pending_visits[$];  // visits still owed by the block
   stim_row_type stim_table[$];

   int mismatches     = 0;
   int visits_checked = 0;
   int quiet_cycles   = 0;
   int rx_hold        = 0;
   logic tx_calm = 1'b0;          // sender never idles while set
   logic rx_calm = 1'b0;          // receiver never stalls while set

   adjacency_matrix_graph_traversal #(.MAX_NODES(NODE_LIMIT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Graph walker. Loads update the local matrix. A traversal fills walk_out
   // with the visits in order. Edges to nodes at or above the node count
   // are masked off, and a node count above 32 saturates. A start outside
   // the graph yields a single error visit and changes nothing.
   // -------------------------------------------------------------------------
   function automatic void walk_graph(input stim_row_type r);
      int unsigned       n, head, tail, depth, cur, i;
      logic [ROW_W-1:0]  mask, row, cand;
      logic [NODE_W-1:0] frontier [NODE_LIMIT];
      visit_type         hit;
      walk_out.delete();
      if (r.mode == MODE_LOAD) begin
         adj_rows[r.row_index] = r.row_bits;
         return;
      end
      if (r.mode == MODE_UNUSED)
         return;
      n = (nodes_in_use > NODE_LIMIT) ? NODE_LIMIT : nodes_in_use;
      if (r.start_node >= n) begin
         hit = '0;
         hit.node  = r.start_node;
         hit.last  = 1'b1;
         hit.error = 1'b1;
         walk_out.push_back(hit);
         return;
      end
      mask = (n >= ROW_W) ? '1 : ((32'd1 << n) - 32'd1);
      visited_nodes = 32'd1 << r.start_node;
      hit = '0;
      hit.node = r.start_node;
      walk_out.push_back(hit);
      frontier[0] = r.start_node;
      if (r.mode == MODE_BFS) begin
         head = 0;
         tail = 1;
         while (head < tail && head < NODE_LIMIT) begin
            cur = frontier[head];
            head++;
            row = adj_rows[cur] & mask;
            for (i = 0; i < n; i++) begin
               if (row[i] && !visited_nodes[i] && tail < NODE_LIMIT) begin
                  visited_nodes[i] = 1'b1;
                  hit.node = NODE_W'(i);
                  walk_out.push_back(hit);
                  frontier[tail] = NODE_W'(i);
                  tail++;
               end
            end
         end
      end else begin
         // preorder: always descend into the lowest unvisited neighbour
         depth = 1;
         while (depth > 0) begin
            cur  = frontier[depth-1];
            cand = adj_rows[cur] & mask & ~visited_nodes;
            if (cand == '0 || depth >= NODE_LIMIT) begin
               depth--;
            end else begin
               i = 0;
               while (!cand[i])
                  i++;
               visited_nodes[i] = 1'b1;
               hit.node = NODE_W'(i);
               walk_out.push_back(hit);
               frontier[depth] = NODE_W'(i);
               depth++;
            end
         end
      end
      hit = walk_out[walk_out.size()-1];
      hit.last        = 1'b1;
      hit.all_reached = (visited_nodes == mask);
      walk_out[walk_out.size()-1] = hit;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at visit %0d: %s", visits_checked, msg);
      mismatches++;
   endtask

   // table builders
   task automatic tab_item(input logic [MODE_W-1:0] mode, input logic [NODE_W-1:0] idx,
                           input logic [ROW_W-1:0] bits, input logic [NODE_W-1:0] start);
      stim_row_type r;
      r = '0;
      r.mode       = mode;
      r.row_index  = idx;
      r.row_bits   = bits;
      r.start_node = start;
      stim_table.push_back(r);
   endtask

   task automatic tab_csr(input logic [CNT_W-1:0] value);
      stim_row_type r;
      r = '0;
      r.is_csr     = 1'b1;
      r.node_count = value;
      stim_table.push_back(r);
   endtask

   // traversal whose single visit is obvious: typed in, not predicted
   task automatic tab_typed(input logic [MODE_W-1:0] mode, input logic [NODE_W-1:0] start,
                            input logic err, input logic all);
      stim_row_type r;
      r = '0;
      r.mode                    = mode;
      r.start_node              = start;
      r.typed                   = 1'b1;
      r.typed_visit.node        = start;
      r.typed_visit.last        = 1'b1;
      r.typed_visit.error       = err;
      r.typed_visit.all_reached = all;
      stim_table.push_back(r);
   endtask

   // Drive one request transfer after an idle gap. tvalid is only dropped
   // when a gap follows, so back-to-back transfers keep it high.
   task automatic send_request(input stim_row_type r, input int gap);
      int k;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.mode;
      req_tdata  <= {{(REQ_TDATA_W-START_LSB-NODE_W){1'b0}},
                     r.start_node, r.row_bits, r.row_index};
      do @(posedge clock); while (!req_tready);
      walk_graph(r);
      if (r.typed) begin
         pending_visits.push_back(r.typed_visit);
      end else begin
         for (k = 0; k < walk_out.size(); k++)
            pending_visits.push_back(walk_out[k]);
      end
   endtask

   // Wait until every visit owed has arrived, then leave the block quiet
   // for a while before the next register write.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_visits.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write: setup then access; only ever issued with the block idle
   task automatic write_node_count(input logic [CNT_W-1:0] value);
      settle();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_NODE_COUNT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      nodes_in_use = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Response side: check each transfer against the oldest owed visit, then
   // draw a stall before the next one.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      visit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_visits.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, node %0d",
                                      rsp_tdata[NODE_W-1:0]));
         end else begin
            want = pending_visits.pop_front();
            if (rsp_tdata[NODE_W-1:0] !== want.node)
               report_mismatch($sformatf("node got %0d want %0d",
                                         rsp_tdata[NODE_W-1:0], want.node));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last got %b want %b", rsp_tlast, want.last));
            if (rsp_tuser[TUSER_ERROR_BIT] !== want.error)
               report_mismatch($sformatf("error got %b want %b",
                                         rsp_tuser[TUSER_ERROR_BIT], want.error));
            if (rsp_tuser[TUSER_ALL_BIT] !== want.all_reached)
               report_mismatch($sformatf("all_reached got %b want %b",
                                         rsp_tuser[TUSER_ALL_BIT], want.all_reached));
         end
         visits_checked++;
         rx_hold = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
         if (rx_hold > 0)
            rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         if (rx_hold <= 1)
            rsp_tready <= 1'b1;
         rx_hold = rx_hold - 1;
      end
   end

   // watchdog: any transfer on any port restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int               i, phase, sent, dice, n_eff;
      stim_row_type     r;
      logic [CNT_W-1:0] count_pick;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= MODE_LOAD;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_NODE_COUNT_ADDR;
      csr_pwdata  <= '0;
      for (i = 0; i < NODE_LIMIT; i++)
         adj_rows[i] = '0;
      visited_nodes = '0;
      nodes_in_use  = NODE_COUNT_RESET;

      // empty graph straight out of reset: each walk is just its start
      tab_typed(MODE_BFS, 5'd0, 1'b0, 1'b0);
      tab_typed(MODE_DFS, 5'd31, 1'b0, 1'b0);
      // star from node 0 reaches all 32 nodes: longest walk
      tab_item(MODE_LOAD, 5'd0, 32'hFFFF_FFFF, 5'd0);
      tab_item(MODE_BFS, 5'd0, 32'h0, 5'd0);
      tab_item(MODE_DFS, 5'd0, 32'h0, 5'd0);
      // self loop on node 5 must not revisit it
      tab_item(MODE_LOAD, 5'd5, 32'h8000_0020, 5'd0);
      tab_item(MODE_LOAD, 5'd31, 32'h5555_5555, 5'd0);
      tab_item(MODE_BFS, 5'd0, 32'h0, 5'd5);
      tab_item(MODE_DFS, 5'd0, 32'h0, 5'd31);
      tab_item(MODE_LOAD, 5'd0, 32'h0, 5'd0);
      // unused mode posing as a load of row 0; the last walk would show it
      tab_item(MODE_UNUSED, 5'd0, 32'h5A5A_5A5A, 5'd17);
      // single-node graph: start 0 reaches everything, anything else fails
      tab_csr(6'd1);
      tab_typed(MODE_BFS, 5'd0, 1'b0, 1'b1);
      tab_typed(MODE_BFS, 5'd1, 1'b1, 1'b0);
      tab_typed(MODE_DFS, 5'd31, 1'b1, 1'b0);
      // zero nodes: every start is out of range
      tab_csr(6'd0);
      tab_typed(MODE_BFS, 5'd0, 1'b1, 1'b0);
      // register above 32 saturates
      tab_csr(6'd63);
      tab_item(MODE_DFS, 5'd0, 32'h0, 5'd5);
      // edges past node_count are ignored
      tab_csr(6'd8);
      tab_item(MODE_LOAD, 5'd7, 32'hFFFF_FF00, 5'd0);
      tab_item(MODE_BFS, 5'd0, 32'h0, 5'd7);
      tab_typed(MODE_DFS, 5'd8, 1'b1, 1'b0);
      tab_csr(6'd32);
      tab_item(MODE_BFS, 5'd0, 32'h0, 5'd31);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < stim_table.size(); i++) begin
         if (stim_table[i].is_csr)
            write_node_count(stim_table[i].node_count);
         else
            send_request(stim_table[i], $urandom_range(0, GAP_MAX));
      end

      // random phases: new node_count, then a mix of loads and walks over
      // the graph built up so far
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         dice = $urandom_range(0, 15);
         if (dice == 0)
            count_pick = 6'd0;
         else if (dice <= 2)
            count_pick = 6'd1;
         else if (dice <= 4)
            count_pick = 6'd32;
         else if (dice == 5)
            count_pick = CNT_W'($urandom_range(33, 63));
         else
            count_pick = CNT_W'($urandom_range(2, 31));
         write_node_count(count_pick);
         n_eff   = (count_pick > NODE_LIMIT) ? NODE_LIMIT : count_pick;
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            r = '0;
            dice = $urandom_range(0, 15);
            if (dice == 0)
               r.mode = MODE_UNUSED;
            else if (dice <= 7)
               r.mode = MODE_LOAD;
            else if (dice <= 11)
               r.mode = MODE_BFS;
            else
               r.mode = MODE_DFS;
            // mostly rows and starts inside the graph so walks go deep
            if (n_eff > 0 && $urandom_range(0, 3) != 0)
               r.row_index = NODE_W'($urandom_range(0, n_eff - 1));
            else
               r.row_index = NODE_W'($urandom_range(0, 31));
            if (n_eff > 0 && $urandom_range(0, 7) != 0)
               r.start_node = NODE_W'($urandom_range(0, n_eff - 1));
            else
               r.start_node = NODE_W'($urandom_range(0, 31));
            // density varies: sparse gives long chains, dense gives wide fans
            case ($urandom_range(0, 3))
               0: r.row_bits = $urandom;
               1: r.row_bits = $urandom & $urandom & $urandom;
               2: r.row_bits = (32'd1 << $urandom_range(0, 31)) |
                               (32'd1 << $urandom_range(0, 31));
               default: r.row_bits = $urandom | $urandom;
            endcase
            send_request(r, tx_calm ? 0 : $urandom_range(0, GAP_MAX));
            if (r.mode != MODE_UNUSED)
               sent++;
         end
      end

      settle();
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
rtl/amgt_pkg.sv
rtl/amgt_adj_mem.sv
rtl/amgt_list_mem.sv
rtl/adjacency_matrix_graph_traversal.sv
rtl/amgt_checker.sv
bench/tb_top.sv
